FILE: rtl/nfrs_pkg.sv
// Package for the nearest free region selector.
// Holds field widths, register indexes, region state codes and the stage records.
// No dependencies.
package nfrs_pkg;

  localparam int ADDR_W  = 64;
  localparam int STATE_W = 2;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET_ADDRESS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REQUIRED_SIZE  = 1'd1;

  localparam logic [STATE_W-1:0] STATE_FREE     = 2'd0;
  localparam logic [STATE_W-1:0] STATE_RESERVED = 2'd1;

  localparam logic [ADDR_W-1:0] DIST_INIT = {ADDR_W{1'b1}};

  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] fin;
    logic [ADDR_W-1:0] place;
    logic              qual;
    logic              last;
  } span_t;

  typedef struct packed {
    logic [ADDR_W-1:0] head;
    logic [ADDR_W-1:0] tail;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] place;
    logic              qual;
    logic              last;
  } cand_t;

endpackage

FILE: rtl/nfrs_prep.sv
// Input register and region end / tail placement stage.
// Depends on nfrs_pkg.
module nfrs_prep (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [nfrs_pkg::ADDR_W-1:0]   region_base,
  input  logic [nfrs_pkg::ADDR_W-1:0]   region_size,
  input  logic [nfrs_pkg::STATE_W-1:0]  region_state,
  input  logic                          last_region,
  input  logic [nfrs_pkg::ADDR_W-1:0]   required_size,
  output logic                          out_valid,
  input  logic                          out_ready,
  output nfrs_pkg::span_t               span
);
  import nfrs_pkg::*;

  logic                a_valid;
  logic [ADDR_W-1:0]   a_base;
  logic [ADDR_W-1:0]   a_size;
  logic [STATE_W-1:0]  a_state;
  logic                a_last;
  logic                b_ready;
  logic [ADDR_W-1:0]   fin;
  span_t               span_next;

  assign b_ready  = !out_valid || out_ready;
  assign in_ready = !a_valid || b_ready;

  assign fin = a_base + a_size;

  always_comb begin
    span_next.base  = a_base;
    span_next.fin   = fin;
    span_next.place = fin - required_size;
    span_next.qual  = ((a_state == STATE_FREE) || (a_state == STATE_RESERVED)) &&
                      (a_size > required_size);
    span_next.last  = a_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) a_valid <= in_valid;
      if (b_ready) out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_base  <= region_base;
      a_size  <= region_size;
      a_state <= region_state;
      a_last  <= last_region;
    end
    if (a_valid && b_ready) begin
      span <= span_next;
    end
  end

endmodule

FILE: rtl/nfrs_dist.sv
// Head and tail distance stage: absolute distances of both region edges to the target.
// Depends on nfrs_pkg.
module nfrs_dist (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  nfrs_pkg::span_t              span,
  input  logic [nfrs_pkg::ADDR_W-1:0]  target_address,
  output logic                         out_valid,
  input  logic                         out_ready,
  output nfrs_pkg::cand_t              cand
);
  import nfrs_pkg::*;

  cand_t cand_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    cand_next.head  = (span.base > target_address) ? (span.base - target_address)
                                                   : (target_address - span.base);
    cand_next.tail  = (span.fin > target_address) ? (span.fin - target_address)
                                                  : (target_address - span.fin);
    cand_next.base  = span.base;
    cand_next.place = span.place;
    cand_next.qual  = span.qual;
    cand_next.last  = span.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cand <= cand_next;
    end
  end

endmodule

FILE: rtl/nfrs_track.sv
// Running nearest-candidate tracker and result register.
// Depends on nfrs_pkg.
module nfrs_track (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  nfrs_pkg::cand_t              cand,
  output logic                         res_valid,
  input  logic                         res_ready,
  output logic [nfrs_pkg::ADDR_W-1:0]  recommended_address,
  output logic                         found
);
  import nfrs_pkg::*;

  logic [ADDR_W-1:0] best_distance;
  logic [ADDR_W-1:0] best_base;
  logic [ADDR_W-1:0] best_place;
  logic              head_closer;
  logic              have_best;

  logic              head_wins;
  logic              take;
  logic              consume;
  logic [ADDR_W-1:0] best_distance_next;
  logic [ADDR_W-1:0] best_base_next;
  logic [ADDR_W-1:0] best_place_next;
  logic              head_closer_next;
  logic              have_best_next;
  logic              found_next;
  logic [ADDR_W-1:0] addr_next;

  assign in_ready = !(cand.last && res_valid && !res_ready);
  assign consume  = in_valid && in_ready;

  assign head_wins = cand.head < cand.tail;
  assign take      = cand.qual && (head_wins ? (cand.head < best_distance)
                                             : (cand.tail < best_distance));

  always_comb begin
    best_distance_next = best_distance;
    best_base_next     = best_base;
    best_place_next    = best_place;
    head_closer_next   = head_closer;
    have_best_next     = have_best;
    if (take) begin
      best_distance_next = head_wins ? cand.head : cand.tail;
      best_base_next     = cand.base;
      best_place_next    = cand.place;
      head_closer_next   = head_wins;
      have_best_next     = 1'b1;
    end
    found_next = have_best_next && (best_base_next != '0);
    addr_next  = '0;
    if (found_next) addr_next = head_closer_next ? best_base_next : best_place_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_distance <= DIST_INIT;
      have_best     <= 1'b0;
      res_valid     <= 1'b0;
    end else begin
      if (consume) begin
        if (cand.last) begin
          best_distance <= DIST_INIT;
          have_best     <= 1'b0;
        end else begin
          best_distance <= best_distance_next;
          have_best     <= have_best_next;
        end
      end
      if (consume && cand.last) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (consume) begin
      best_base   <= best_base_next;
      best_place  <= best_place_next;
      head_closer <= head_closer_next;
    end
    if (consume && cand.last) begin
      recommended_address <= addr_next;
      found               <= found_next;
    end
  end

endmodule

FILE: rtl/nearest_free_region_select.sv
// Nearest free region select: picks the placement nearest the target from a descriptor stream.
// A list's last descriptor passes the input, span and candidate registers to the result register.
// Throughput: one descriptor per cycle; stalls only while a result waits and another
// list end reaches the tracker.
// Reset (synchronous, rst high): empties all stages, restarts the search, zeroes both registers.
// Depends on nfrs_pkg, nfrs_prep, nfrs_dist, nfrs_track.
module nearest_free_region_select (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [nfrs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nfrs_pkg::ADDR_W-1:0]     cfg_data,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [2*nfrs_pkg::ADDR_W-1:0]   s_tdata,  // region_base, region_size
  input  logic [nfrs_pkg::STATE_W-1:0]    s_tuser,  // region_state
  input  logic                            s_tlast,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [nfrs_pkg::ADDR_W-1:0]     m_tdata,  // recommended_address
  output logic                            m_tuser   // found
);
  import nfrs_pkg::*;

  logic [ADDR_W-1:0] target_address;
  logic [ADDR_W-1:0] required_size;

  logic  span_valid;
  logic  span_ready;
  span_t span;
  logic  cand_valid;
  logic  cand_ready;
  cand_t cand;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_address <= '0;
      required_size  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TARGET_ADDRESS: target_address <= cfg_data;
        REG_REQUIRED_SIZE:  required_size  <= cfg_data;
        default: ;
      endcase
    end
  end

  nfrs_prep u_prep (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .region_base   (s_tdata[ADDR_W-1:0]),
    .region_size   (s_tdata[2*ADDR_W-1:ADDR_W]),
    .region_state  (s_tuser),
    .last_region   (s_tlast),
    .required_size (required_size),
    .out_valid     (span_valid),
    .out_ready     (span_ready),
    .span          (span)
  );

  nfrs_dist u_dist (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (span_valid),
    .in_ready       (span_ready),
    .span           (span),
    .target_address (target_address),
    .out_valid      (cand_valid),
    .out_ready      (cand_ready),
    .cand           (cand)
  );

  nfrs_track u_track (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (cand_valid),
    .in_ready            (cand_ready),
    .cand                (cand),
    .res_valid           (m_tvalid),
    .res_ready           (m_tready),
    .recommended_address (m_tdata),
    .found               (m_tuser)
  );

`ifndef SYNTH
  a_no_found_zero_addr: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == '0)
    else $error("result without a region carries a nonzero address");

  a_stall_only_on_result: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input held off without a waiting result");

  a_result_from_list_end: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(cand_valid && cand_ready && cand.last))
    else $error("result raised without a list end reaching the tracker");
`endif

endmodule

FILE: verif/nfrs_checker.sv
// Checker for the nearest free region selector: watches the register port and both streams.
// Predicts one placement per region list and compares each result field by field.
// Depends on nfrs_pkg.
module nfrs_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [nfrs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nfrs_pkg::ADDR_W-1:0]     cfg_data,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [2*nfrs_pkg::ADDR_W-1:0]   s_tdata,  // region_base, region_size
  input  logic [nfrs_pkg::STATE_W-1:0]    s_tuser,  // region_state
  input  logic                            s_tlast,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [nfrs_pkg::ADDR_W-1:0]     m_tdata,  // recommended_address
  input  logic                            m_tuser,  // found
  output int                              mismatches,
  output int                              outstanding,
  output int                              placements,
  output int                              hits
);
  timeunit 1ns;
  timeprecision 1ps;
  import nfrs_pkg::*;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              found;
  } placement_t;

  placement_t placement_q[$];

  logic [ADDR_W-1:0] want_target;
  logic [ADDR_W-1:0] want_size;
  logic [ADDR_W-1:0] near_dist;
  logic [ADDR_W-1:0] near_base;
  logic [ADDR_W-1:0] near_len;
  logic              near_head;
  logic              near_valid;

  initial begin
    mismatches  = 0;
    outstanding = 0;
    placements  = 0;
    hits        = 0;
  end

  task automatic clear_search();
    near_dist  = '1;
    near_base  = '0;
    near_len   = '0;
    near_head  = 1'b0;
    near_valid = 1'b0;
  endtask

  task automatic scan_region(input logic [ADDR_W-1:0] base, input logic [ADDR_W-1:0] size,
                             input logic [STATE_W-1:0] kind, input logic fin);
    logic [ADDR_W-1:0] end_addr;
    logic [ADDR_W-1:0] head_gap;
    logic [ADDR_W-1:0] tail_gap;
    logic [ADDR_W-1:0] gap;
    logic              head_wins;
    placement_t        p;
    if ((kind == STATE_FREE || kind == STATE_RESERVED) && size > want_size) begin
      end_addr  = base + size;
      head_gap  = (base > want_target) ? base - want_target : want_target - base;
      tail_gap  = (end_addr > want_target) ? end_addr - want_target : want_target - end_addr;
      head_wins = head_gap < tail_gap;
      gap       = head_wins ? head_gap : tail_gap;
      if (gap < near_dist) begin
        near_dist  = gap;
        near_base  = base;
        near_len   = size;
        near_head  = head_wins;
        near_valid = 1'b1;
      end
    end
    if (fin) begin
      p.found = near_valid && near_base != '0;
      p.addr  = '0;
      if (p.found)
        p.addr = near_head ? near_base : near_base + near_len - want_size;
      placement_q = {placement_q, p};
      clear_search();
    end
  endtask

  task automatic flag(input string what, input placement_t exp);
    if (mismatches < 10)
      $display("[%0t] %s: expected addr %h found %b, got addr %h found %b",
               $time, what, exp.addr, exp.found, m_tdata, m_tuser);
    mismatches++;
  endtask

  always @(posedge clk) begin
    placement_t exp;
    if (rst) begin
      want_target = '0;
      want_size   = '0;
      clear_search();
      placement_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TARGET_ADDRESS: want_target = cfg_data;
          REG_REQUIRED_SIZE:  want_size   = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        scan_region(s_tdata[ADDR_W-1:0], s_tdata[2*ADDR_W-1:ADDR_W], s_tuser, s_tlast);
      if (m_tvalid && m_tready) begin
        placements++;
        if (m_tuser === 1'b1)
          hits++;
        if (placement_q.size() == 0) begin
          exp = '0;
          flag("unexpected result", exp);
        end else begin
          exp = placement_q.pop_front();
          if (m_tdata !== exp.addr || m_tuser !== exp.found)
            flag("placement mismatch", exp);
        end
      end
    end
    outstanding = placement_q.size();
  end

endmodule

FILE: verif/testbench.sv
// Top of the nearest free region selector testbench: clock, reset, region lists and verdict.
// Drives directed then random lists over several register settings, with bursty input
// and a stalling receiver. Depends on nfrs_pkg, nfrs_checker and the block itself.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import nfrs_pkg::*;

  localparam logic [STATE_W-1:0] STATE_COMMITTED = 2'd2;
  localparam logic [STATE_W-1:0] STATE_OTHER     = 2'd3;
  localparam logic [ADDR_W-1:0]  ALL_ONES        = '1;
  localparam int                 CYCLE_LIMIT     = 300000;

  logic                  clk;
  logic                  rst       = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_TARGET_ADDRESS;
  logic [ADDR_W-1:0]     cfg_data  = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [2*ADDR_W-1:0]   s_tdata   = '0;  // region_base, region_size
  logic [STATE_W-1:0]    s_tuser   = STATE_FREE;  // region_state
  logic                  s_tlast   = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [ADDR_W-1:0]     m_tdata;  // recommended_address
  logic                  m_tuser;  // found

  int mismatches;
  int outstanding;
  int placements;
  int hits;

  logic [ADDR_W-1:0] cur_target = '0;
  logic [ADDR_W-1:0] cur_size   = '0;
  int  regions_sent = 0;
  int  lists_sent   = 0;
  int  settings     = 1;
  int  burst_left   = 8;
  bit  no_gaps      = 1'b0;
  logic squeeze     = 1'b0;
  int  cycle_count  = 0;

  int  hold_left = 0;
  bit  hold_done = 1'b0;
  int  rx_mode   = 0;
  int  rx_left   = 0;

  nearest_free_region_select u_top (.*);

  nfrs_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("nearest_free_region_select verification failed");
      $finish;
    end
  end

  // receiver: changing stall pattern, one long hold-off when squeezed
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (squeeze && !hold_done) begin
      hold_left <= 400;
      hold_done <= 1'b1;
      m_tready  <= 1'b0;
    end else if (rx_left == 0) begin
      rx_mode  <= $urandom_range(0, 2);
      rx_left  <= $urandom_range(10, 80);
      m_tready <= 1'b1;
    end else begin
      rx_left <= rx_left - 1;
      case (rx_mode)
        0:       m_tready <= 1'b1;
        1:       m_tready <= 1'($urandom_range(0, 1));
        default: m_tready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  function automatic logic [ADDR_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] value);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    if (idx == REG_TARGET_ADDRESS)
      cur_target = value;
    else
      cur_size = value;
  endtask

  task automatic set_search(input logic [ADDR_W-1:0] target, input logic [ADDR_W-1:0] need);
    write_reg(REG_TARGET_ADDRESS, target);
    write_reg(REG_REQUIRED_SIZE, need);
    settings++;
  endtask

  // drop valid, drain every pending placement and let the pipeline empty
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic push_region(input logic [ADDR_W-1:0] base, input logic [ADDR_W-1:0] size,
                             input logic [STATE_W-1:0] kind, input logic fin);
    s_tdata  <= {size, base};
    s_tuser  <= kind;
    s_tlast  <= fin;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    regions_sent++;
    if (fin)
      lists_sent++;
    if (!no_gaps) begin
      if (burst_left == 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = $urandom_range(1, 24);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic send_list(input int len);
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] size;
    logic [ADDR_W-1:0] off;
    logic [STATE_W-1:0] kind;
    int pick;
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 4) == 0) begin
        base = rand64();
        size = rand64();
        kind = STATE_W'($urandom_range(0, 3));
      end else begin
        case ($urandom_range(0, 3))
          0:       off = ADDR_W'($urandom_range(0, 255));
          1:       off = ADDR_W'($urandom);
          2:       off = {$urandom_range(0, 15), $urandom};
          default: off = rand64();
        endcase
        base = $urandom_range(0, 1) ? cur_target + off : cur_target - off;
        case ($urandom_range(0, 4))
          0, 1:    size = cur_size + ADDR_W'($urandom_range(1, 4));
          2:       size = cur_size + ADDR_W'($urandom) + ADDR_W'(1);
          3:       size = cur_size - ADDR_W'($urandom_range(0, 2));
          default: size = rand64();
        endcase
        pick = $urandom_range(0, 9);
        kind = (pick < 4) ? STATE_FREE : (pick < 7) ? STATE_RESERVED :
               (pick == 8) ? STATE_COMMITTED : STATE_OTHER;
      end
      push_region(base, size, kind, k == len - 1);
    end
  endtask

  initial begin
    int phase_items;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // registers at reset values
    push_region(64'h100, 64'h10, STATE_FREE, 1'b1);
    settle();

    set_search(64'h8000, 64'h100);
    push_region(64'h8000, 64'h1000, STATE_COMMITTED, 1'b0);
    push_region(64'h8010, 64'h1000, STATE_OTHER, 1'b0);
    push_region(64'h8020, 64'h100, STATE_FREE, 1'b0);
    push_region(64'h7000, 64'h200, STATE_RESERVED, 1'b0);
    push_region(64'h8E00, 64'h300, STATE_FREE, 1'b0);
    push_region(64'h20000, 64'h101, STATE_FREE, 1'b1);
    push_region(64'h7F00, 64'h200, STATE_FREE, 1'b1);
    push_region(64'h0, 64'h10000, STATE_FREE, 1'b1);
    push_region(64'h8000, ALL_ONES, STATE_COMMITTED, 1'b1);
    settle();

    set_search(ALL_ONES, 64'h0);
    push_region(64'hFFFF_FFFF_FFFF_FF00, 64'h200, STATE_FREE, 1'b0);
    push_region(ALL_ONES, ALL_ONES, STATE_RESERVED, 1'b1);
    settle();

    write_reg(REG_REQUIRED_SIZE, ALL_ONES);
    push_region(64'h1, ALL_ONES, STATE_FREE, 1'b1);
    settle();

    set_search(64'h0, ALL_ONES - 1);
    push_region(64'h10, ALL_ONES, STATE_FREE, 1'b1);
    settle();

    set_search(64'h1000, 64'h40);
    push_region(64'h900, 64'h800, STATE_FREE, 1'b0);
    push_region(64'h1080, 64'h41, STATE_RESERVED, 1'b0);
    push_region(64'h2000, 64'h1000, STATE_OTHER, 1'b1);
    settle();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0:       set_search(64'h0, 64'h0);
        1:       set_search(ALL_ONES, ALL_ONES - 1);
        2:       set_search(rand64(), ADDR_W'($urandom_range(0, 65535)));
        3:       set_search(rand64(), ALL_ONES);
        4:       set_search(ADDR_W'($urandom_range(0, 4095)), ADDR_W'($urandom_range(0, 255)));
        5:       set_search(rand64(), rand64());
        default: set_search(rand64(), ADDR_W'($urandom));
      endcase
      no_gaps = (ph == 6);
      phase_items = regions_sent;
      while (regions_sent - phase_items < 70)
        send_list(($urandom_range(0, 7) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6));
      settle();
    end

    // hold the receiver off while lists keep coming
    set_search(rand64(), ADDR_W'($urandom_range(0, 255)));
    no_gaps = 1'b1;
    squeeze <= 1'b1;
    phase_items = regions_sent;
    while (regions_sent - phase_items < 60)
      send_list($urandom_range(1, 2));
    no_gaps = 1'b0;
    settle();

    $display("Sent %0d regions in %0d lists over %0d register settings", regions_sent,
             lists_sent, settings);
    $display("Checked %0d placements, %0d with a region found", placements, hits);
    if (mismatches == 0)
      $display("nearest_free_region_select verification clean");
    else
      $display("nearest_free_region_select verification failed");
    $finish;
  end

endmodule
